### rtl/cpt_pkg.sv
// Shared types and constants for the closest point on triangle block.
package cpt_pkg;

	localparam int CPT_COORD_BITS = 32;

	// Multiplier slice widths: cofactor products and numerator products.
	localparam int CPT_VMUL_CHUNK = 17;
	localparam int CPT_NMUL_CHUNK = 8;

	typedef enum logic [2:0] {
		REG_VA   = 3'd0,
		REG_VB   = 3'd1,
		REG_EAB  = 3'd2,
		REG_VC   = 3'd3,
		REG_EAC  = 3'd4,
		REG_EBC  = 3'd5,
		REG_FACE = 3'd6
	} region_t;

endpackage

### rtl/cpt_if.sv
// Valid/ready channel interfaces for queries and results.
interface cpt_query_if import cpt_pkg::*; #(parameter int W = CPT_COORD_BITS);
	logic valid;
	logic ready;
	logic signed [W-1:0] p_x, p_y, p_z;
	logic signed [W-1:0] a_x, a_y, a_z;
	logic signed [W-1:0] b_x, b_y, b_z;
	logic signed [W-1:0] c_x, c_y, c_z;

	modport source (output valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, input ready);
	modport sink (input valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, output ready);
endinterface

interface cpt_result_if import cpt_pkg::*; #(parameter int W = CPT_COORD_BITS);
	logic valid;
	logic ready;
	logic signed [W-1:0] q_x, q_y, q_z;
	region_t region;
	logic degenerate;

	modport source (output valid, q_x, q_y, q_z, region, degenerate, input ready);
	modport sink (input valid, q_x, q_y, q_z, region, degenerate, output ready);
endinterface

### rtl/cpt_mul.sv
// Pipelined signed multiplier that consumes one slice of operand b per stage.
module cpt_mul import cpt_pkg::*; #(
	parameter int WA = 16,
	parameter int WB = 16,
	parameter int CH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WA-1:0]     a,
	input  logic signed [WB-1:0]     b,
	output logic signed [WA+WB-1:0]  p
);
	localparam int NST = (WB + CH - 1) / CH;
	localparam int PW  = WA + WB;
	localparam int BX  = NST * CH;

	logic signed [WA-1:0] a_q   [NST-1];
	logic signed [BX-1:0] b_q   [NST-1];
	logic signed [PW-1:0] acc_q [NST];
	logic signed [BX-1:0] bx;

	assign bx = BX'(b);

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic signed [WA-1:0] a_in;
		logic signed [BX-1:0] b_in;
		logic signed [PW-1:0] acc_in;
		logic signed [CH:0]   cs;
		logic signed [WA+CH:0] t;

		if (k == 0) begin : g_first
			assign a_in   = a;
			assign b_in   = bx;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_q[k-1];
			assign b_in   = b_q[k-1];
			assign acc_in = acc_q[k-1];
		end

		// Lower slices are unsigned, the top slice carries the sign of b.
		if (k == NST - 1) begin : g_top
			assign cs = {b_in[BX-1], b_in[k*CH +: CH]};
		end else begin : g_low
			assign cs = {1'b0, b_in[k*CH +: CH]};
		end

		assign t = a_in * cs;

		always_ff @(posedge clk) begin
			if (en) begin
				acc_q[k] <= acc_in + (PW'(t) <<< (k * CH));
			end
		end

		if (k < NST - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					a_q[k] <= a_in;
					b_q[k] <= b_in;
				end
			end
		end
	end

	assign p = acc_q[NST-1];

endmodule

### rtl/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
module cpt_div import cpt_pkg::*; #(
	parameter int NW  = 16,
	parameter int DWD = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DWD-1:0] den,
	output logic signed [NW:0]   quo
);
	logic [NW-1:0]   n_q   [NW+1];
	logic [DWD-1:0]  r_q   [NW];
	logic [DWD-1:0]  d_q   [NW];
	logic            neg_q [NW+1];
	logic signed [NW:0] quo_q;

	// Magnitudes and result sign.
	always_ff @(posedge clk) begin
		if (en) begin
			n_q[0]   <= num[NW-1] ? (~num + 1'b1) : num;
			d_q[0]   <= den[DWD-1] ? (~den + 1'b1) : den;
			r_q[0]   <= '0;
			neg_q[0] <= num[NW-1] ^ den[DWD-1];
		end
	end

	for (genvar i = 1; i <= NW; i++) begin : g_bit
		logic [DWD:0]   rs;
		logic [DWD:0]   df;
		logic [DWD-1:0] r_nx;
		logic [NW-1:0]  n_nx;

		assign rs = {r_q[i-1], n_q[i-1][NW-1]};
		assign df = rs - {1'b0, d_q[i-1]};

		always_comb begin
			if (!df[DWD]) begin
				r_nx = df[DWD-1:0];
				n_nx = {n_q[i-1][NW-2:0], 1'b1};
			end else begin
				r_nx = rs[DWD-1:0];
				n_nx = {n_q[i-1][NW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i]   <= n_nx;
				neg_q[i] <= neg_q[i-1];
			end
		end

		if (i < NW) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					r_q[i] <= r_nx;
					d_q[i] <= d_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_q[NW] ? -$signed({1'b0, n_q[NW]}) : $signed({1'b0, n_q[NW]});
		end
	end

	assign quo = quo_q;

endmodule

### rtl/closest_point_on_triangle.sv
// Top level: closest point on a triangle to a query point, fully pipelined.
//
//  Channel  Role    Payload
//  -------  ------  ---------------------------------------------------------
//  query    sink    p_x..p_z, a_x..a_z, b_x..b_z, c_x..c_z (signed Q16.16)
//  result   source  q_x, q_y, q_z (signed Q16.16), region, degenerate
//
// One query can be taken in every cycle while the result side does not stall.
// The pipeline holds LV = ceil((2*COORD_BITS+4)/17) cofactor multiplier stages,
// LN = ceil((COORD_BITS+1)/8) numerator multiplier stages and LD = NW + 2
// divider stages (NW is the numerator width); the divider stages are most of it.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The whole pipeline advances together whenever the output register is empty or
// its transfer completes, so a stall on the result side freezes every stage and
// nothing is lost or repeated.
module closest_point_on_triangle import cpt_pkg::*; #(
	parameter int COORD_BITS = CPT_COORD_BITS
) (
	input logic        clk,
	input logic        arst_n,
	cpt_query_if.sink  query,
	cpt_result_if.source result
);
	localparam int D   = COORD_BITS + 1;         // coordinate differences
	localparam int PD  = 2 * D;                  // one component product
	localparam int DW  = 2 * COORD_BITS + 4;     // dot products
	localparam int EW  = DW + 2;                 // sums of dot products
	localparam int VW  = 2 * DW + 1;             // barycentric cofactors
	localparam int MW  = VW + 2;                 // denominators
	localparam int NW  = VW + D + 1;             // numerators
	localparam int LV  = (DW + CPT_VMUL_CHUNK - 1) / CPT_VMUL_CHUNK;
	localparam int LN  = (D + CPT_NMUL_CHUNK - 1) / CPT_NMUL_CHUNK;
	localparam int LD  = NW + 2;
	localparam int LT  = 7 + LV + LN + LD;
	localparam int GD  = LV + 3;
	localparam int IDX_S6 = 5 + LV + LN;
	localparam logic signed [NW+1:0] QMAX = {{(NW + 3 - COORD_BITS){1'b0}},
		{(COORD_BITS - 1){1'b1}}};
	localparam logic signed [NW+1:0] QMIN = {{(NW + 3 - COORD_BITS){1'b1}},
		{(COORD_BITS - 1){1'b0}}};

	logic          en;
	logic [LT-1:0] v_q;

	// The pipeline moves as one; a transfer into it happens whenever it moves.
	assign en          = !v_q[LT-1] || result.ready;
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LT-2:0], query.valid};
		end
	end

	// Stage 1: edge vectors and offsets of the query point from each corner.
	logic signed [COORD_BITS-1:0] pin [3], ain [3], bin [3], cin [3];
	logic signed [COORD_BITS-1:0] a_s1 [3], b_s1 [3], c_s1 [3];
	logic signed [D-1:0] ab_s1 [3], ac_s1 [3], bc_s1 [3];
	logic signed [D-1:0] ap_s1 [3], bp_s1 [3], cp_s1 [3];

	assign pin = '{query.p_x, query.p_y, query.p_z};
	assign ain = '{query.a_x, query.a_y, query.a_z};
	assign bin = '{query.b_x, query.b_y, query.b_z};
	assign cin = '{query.c_x, query.c_y, query.c_z};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= ain[i];
				b_s1[i]  <= bin[i];
				c_s1[i]  <= cin[i];
				ab_s1[i] <= D'(bin[i]) - D'(ain[i]);
				ac_s1[i] <= D'(cin[i]) - D'(ain[i]);
				bc_s1[i] <= D'(cin[i]) - D'(bin[i]);
				ap_s1[i] <= D'(pin[i]) - D'(ain[i]);
				bp_s1[i] <= D'(pin[i]) - D'(bin[i]);
				cp_s1[i] <= D'(pin[i]) - D'(cin[i]);
			end
		end
	end

	// Stage 2: the eighteen component products. Stage 3: the six dot products,
	// in the order d1 = ab.ap, d2 = ac.ap, d3 = ab.bp, d4 = ac.bp, d5 = ab.cp,
	// d6 = ac.cp.
	logic signed [PD-1:0] pr_s2 [6][3];
	logic signed [DW-1:0] d_s3 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_s2[0][i] <= ab_s1[i] * ap_s1[i];
				pr_s2[1][i] <= ac_s1[i] * ap_s1[i];
				pr_s2[2][i] <= ab_s1[i] * bp_s1[i];
				pr_s2[3][i] <= ac_s1[i] * bp_s1[i];
				pr_s2[4][i] <= ab_s1[i] * cp_s1[i];
				pr_s2[5][i] <= ac_s1[i] * cp_s1[i];
			end
			for (int j = 0; j < 6; j++) begin
				d_s3[j] <= DW'(pr_s2[j][0]) + DW'(pr_s2[j][1]) + DW'(pr_s2[j][2]);
			end
		end
	end

	// Corner data rides alongside until the region decision.
	logic signed [COORD_BITS-1:0] ga_q [GD][3], gb_q [GD][3], gc_q [GD][3];
	logic signed [D-1:0] gab_q [GD][3], gac_q [GD][3], gbc_q [GD][3];

	always_ff @(posedge clk) begin
		if (en) begin
			ga_q[0]  <= a_s1;
			gb_q[0]  <= b_s1;
			gc_q[0]  <= c_s1;
			gab_q[0] <= ab_s1;
			gac_q[0] <= ac_s1;
			gbc_q[0] <= bc_s1;
			for (int k = 1; k < GD; k++) begin
				ga_q[k]  <= ga_q[k-1];
				gb_q[k]  <= gb_q[k-1];
				gc_q[k]  <= gc_q[k-1];
				gab_q[k] <= gab_q[k-1];
				gac_q[k] <= gac_q[k-1];
				gbc_q[k] <= gbc_q[k-1];
			end
		end
	end

	// Cofactor products: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6,
	// va = d3*d6 - d5*d4.
	logic signed [2*DW-1:0] vp [6];
	logic signed [DW-1:0]   dd_q [LV][6];

	cpt_mul #(.WA(DW), .WB(DW), .CH(CPT_VMUL_CHUNK)) u_mul_v0 (
		.clk(clk), .en(en), .a(d_s3[0]), .b(d_s3[3]), .p(vp[0]));
	cpt_mul #(.WA(DW), .WB(DW), .CH(CPT_VMUL_CHUNK)) u_mul_v1 (
		.clk(clk), .en(en), .a(d_s3[2]), .b(d_s3[1]), .p(vp[1]));
	cpt_mul #(.WA(DW), .WB(DW), .CH(CPT_VMUL_CHUNK)) u_mul_v2 (
		.clk(clk), .en(en), .a(d_s3[4]), .b(d_s3[1]), .p(vp[2]));
	cpt_mul #(.WA(DW), .WB(DW), .CH(CPT_VMUL_CHUNK)) u_mul_v3 (
		.clk(clk), .en(en), .a(d_s3[0]), .b(d_s3[5]), .p(vp[3]));
	cpt_mul #(.WA(DW), .WB(DW), .CH(CPT_VMUL_CHUNK)) u_mul_v4 (
		.clk(clk), .en(en), .a(d_s3[2]), .b(d_s3[5]), .p(vp[4]));
	cpt_mul #(.WA(DW), .WB(DW), .CH(CPT_VMUL_CHUNK)) u_mul_v5 (
		.clk(clk), .en(en), .a(d_s3[4]), .b(d_s3[3]), .p(vp[5]));

	always_ff @(posedge clk) begin
		if (en) begin
			dd_q[0] <= d_s3;
			for (int k = 1; k < LV; k++) begin
				dd_q[k] <= dd_q[k-1];
			end
		end
	end

	// Stage 4: cofactors and the edge sums used by the region tests.
	logic signed [VW-1:0] va_s4, vb_s4, vc_s4;
	logic signed [DW-1:0] d1_s4, d2_s4, d3_s4, d6_s4;
	logic signed [EW-1:0] e43_s4, e56_s4, mab_s4, mac_s4, mbc_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			vc_s4  <= VW'(vp[0]) - VW'(vp[1]);
			vb_s4  <= VW'(vp[2]) - VW'(vp[3]);
			va_s4  <= VW'(vp[4]) - VW'(vp[5]);
			d1_s4  <= dd_q[LV-1][0];
			d2_s4  <= dd_q[LV-1][1];
			d3_s4  <= dd_q[LV-1][2];
			d6_s4  <= dd_q[LV-1][5];
			e43_s4 <= EW'(dd_q[LV-1][3]) - EW'(dd_q[LV-1][2]);
			e56_s4 <= EW'(dd_q[LV-1][4]) - EW'(dd_q[LV-1][5]);
			mab_s4 <= EW'(dd_q[LV-1][0]) - EW'(dd_q[LV-1][2]);
			mac_s4 <= EW'(dd_q[LV-1][1]) - EW'(dd_q[LV-1][5]);
			mbc_s4 <= EW'(dd_q[LV-1][3]) - EW'(dd_q[LV-1][2])
				+ EW'(dd_q[LV-1][4]) - EW'(dd_q[LV-1][5]);
		end
	end

	// Stage 5: region decision in priority order. Every case that divides is
	// folded into one form per axis: base + (x1*y1 + x2*y2) / m. On an edge the
	// second term is zero; on the face it is ab*vb + ac*vc over va + vb + vc.
	region_t                      reg_c;
	logic                         vert_c;
	logic signed [D-1:0]          x1_c [3], x2_c [3];
	logic signed [VW-1:0]         y1_c, y2_c;
	logic signed [MW-1:0]         m_c;
	logic signed [COORD_BITS-1:0] base_c [3];

	always_comb begin
		reg_c  = REG_FACE;
		vert_c = 1'b0;
		x1_c   = gab_q[GD-1];
		x2_c   = gac_q[GD-1];
		y1_c   = vb_s4;
		y2_c   = vc_s4;
		m_c    = MW'(va_s4) + MW'(vb_s4) + MW'(vc_s4);
		base_c = ga_q[GD-1];
		if (d1_s4 <= 0 && d2_s4 <= 0) begin
			reg_c  = REG_VA;
			vert_c = 1'b1;
		end else if (d3_s4 >= 0 && e43_s4 <= 0) begin
			reg_c  = REG_VB;
			vert_c = 1'b1;
			base_c = gb_q[GD-1];
		end else if (vc_s4 <= 0 && d1_s4 >= 0 && d3_s4 <= 0) begin
			reg_c = REG_EAB;
			x2_c  = '{default: '0};
			y1_c  = VW'(d1_s4);
			y2_c  = '0;
			m_c   = MW'(mab_s4);
		end else if (d6_s4 >= 0 && e56_s4 <= 0) begin
			reg_c  = REG_VC;
			vert_c = 1'b1;
			base_c = gc_q[GD-1];
		end else if (vb_s4 <= 0 && d2_s4 >= 0 && d6_s4 <= 0) begin
			reg_c = REG_EAC;
			x1_c  = gac_q[GD-1];
			x2_c  = '{default: '0};
			y1_c  = VW'(d2_s4);
			y2_c  = '0;
			m_c   = MW'(mac_s4);
		end else if (va_s4 <= 0 && e43_s4 >= 0 && e56_s4 >= 0) begin
			reg_c  = REG_EBC;
			x1_c   = gbc_q[GD-1];
			x2_c   = '{default: '0};
			y1_c   = VW'(e43_s4);
			y2_c   = '0;
			m_c    = MW'(mbc_s4);
			base_c = gb_q[GD-1];
		end
	end

	region_t                      region_s5;
	logic                         vert_s5;
	logic signed [D-1:0]          x1_s5 [3], x2_s5 [3];
	logic signed [VW-1:0]         y1_s5, y2_s5;
	logic signed [MW-1:0]         m_s5;
	logic signed [COORD_BITS-1:0] base_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			region_s5 <= reg_c;
			vert_s5   <= vert_c;
			x1_s5     <= x1_c;
			x2_s5     <= x2_c;
			y1_s5     <= y1_c;
			y2_s5     <= y2_c;
			m_s5      <= m_c;
			base_s5   <= base_c;
		end
	end

	// Numerator products, two per axis.
	logic signed [VW+D-1:0] p1 [3], p2 [3];

	for (genvar k = 0; k < 3; k++) begin : g_num
		cpt_mul #(.WA(VW), .WB(D), .CH(CPT_NMUL_CHUNK)) u_mul_n1 (
			.clk(clk), .en(en), .a(y1_s5), .b(x1_s5[k]), .p(p1[k]));
		cpt_mul #(.WA(VW), .WB(D), .CH(CPT_NMUL_CHUNK)) u_mul_n2 (
			.clk(clk), .en(en), .a(y2_s5), .b(x2_s5[k]), .p(p2[k]));
	end

	region_t                      h_reg_q  [LN];
	logic                         h_vert_q [LN];
	logic signed [COORD_BITS-1:0] h_base_q [LN][3];
	logic signed [MW-1:0]         h_m_q    [LN];

	always_ff @(posedge clk) begin
		if (en) begin
			h_reg_q[0]  <= region_s5;
			h_vert_q[0] <= vert_s5;
			h_base_q[0] <= base_s5;
			h_m_q[0]    <= m_s5;
			for (int k = 1; k < LN; k++) begin
				h_reg_q[k]  <= h_reg_q[k-1];
				h_vert_q[k] <= h_vert_q[k-1];
				h_base_q[k] <= h_base_q[k-1];
				h_m_q[k]    <= h_m_q[k-1];
			end
		end
	end

	// Stage 6: numerator sums and the zero-denominator check. A zero
	// denominator means the start point is returned; on the face it is also
	// flagged as degenerate. The divider then sees a harmless divisor of one.
	logic signed [NW-1:0]         num_s6 [3];
	logic signed [MW-1:0]         den_s6;
	region_t                      region_s6;
	logic                         div_s6, degen_s6;
	logic signed [COORD_BITS-1:0] base_s6 [3];
	logic                         mz;

	assign mz = (h_m_q[LN-1] == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s6[k] <= NW'(p1[k]) + NW'(p2[k]);
			end
			den_s6    <= mz ? MW'(1) : h_m_q[LN-1];
			region_s6 <= h_reg_q[LN-1];
			div_s6    <= !h_vert_q[LN-1] && !mz;
			degen_s6  <= (h_reg_q[LN-1] == REG_FACE) && mz;
			base_s6   <= h_base_q[LN-1];
		end
	end

	logic signed [NW:0] quo [3];

	for (genvar k = 0; k < 3; k++) begin : g_div
		cpt_div #(.NW(NW), .DWD(MW)) u_div (
			.clk(clk), .en(en), .num(num_s6[k]), .den(den_s6), .quo(quo[k]));
	end

	region_t                      t_reg_q  [LD];
	logic                         t_div_q  [LD];
	logic                         t_deg_q  [LD];
	logic signed [COORD_BITS-1:0] t_base_q [LD][3];

	always_ff @(posedge clk) begin
		if (en) begin
			t_reg_q[0]  <= region_s6;
			t_div_q[0]  <= div_s6;
			t_deg_q[0]  <= degen_s6;
			t_base_q[0] <= base_s6;
			for (int k = 1; k < LD; k++) begin
				t_reg_q[k]  <= t_reg_q[k-1];
				t_div_q[k]  <= t_div_q[k-1];
				t_deg_q[k]  <= t_deg_q[k-1];
				t_base_q[k] <= t_base_q[k-1];
			end
		end
	end

	// Stage 7: add the quotient to the start point and saturate to the
	// coordinate range, which only matters for nearly degenerate input.
	logic signed [NW+1:0]         sum_c [3];
	logic signed [COORD_BITS-1:0] q_c [3];
	logic signed [COORD_BITS-1:0] q_s7 [3];
	region_t                      region_s7;
	logic                         degen_s7;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = (NW + 2)'(t_base_q[LD-1][k]) + (NW + 2)'(quo[k]);
			if (!t_div_q[LD-1]) begin
				q_c[k] = t_base_q[LD-1][k];
			end else if (sum_c[k] > QMAX) begin
				q_c[k] = QMAX[COORD_BITS-1:0];
			end else if (sum_c[k] < QMIN) begin
				q_c[k] = QMIN[COORD_BITS-1:0];
			end else begin
				q_c[k] = sum_c[k][COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s7      <= q_c;
			region_s7 <= t_reg_q[LD-1];
			degen_s7  <= t_deg_q[LD-1];
		end
	end

	assign result.valid      = v_q[LT-1];
	assign result.q_x        = q_s7[0];
	assign result.q_y        = q_s7[1];
	assign result.q_z        = q_s7[2];
	assign result.region     = region_s7;
	assign result.degenerate = degen_s7;

	// A valid item never reaches the dividers with a zero divisor.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[IDX_S6] |-> den_s6 != '0)
		else $error("zero divisor entered the divider");

	// Vertex regions never take the divided result.
	a_vert_nodiv: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[LT-2] && t_div_q[LD-1]) |->
		!(t_reg_q[LD-1] == REG_VA || t_reg_q[LD-1] == REG_VB ||
		t_reg_q[LD-1] == REG_VC))
		else $error("vertex region selected a quotient");

	// The degenerate flag is only raised in the face region.
	a_degen_face: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.degenerate) |-> result.region == REG_FACE)
		else $error("degenerate flag outside the face region");

endmodule
